// ----- sv/prec_eval_pkg.sv -----
// shared operator codes, term codes and limits of the expression evaluator
package prec_eval_pkg;

   // operator codes carried with each operand
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_SUB    = 3'd1;
   localparam logic [2:0] OP_MUL    = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_EQUALS = 3'd4;

   // widths of the item fields and of the arithmetic
   localparam int OPERAND_W = 24;
   localparam int OP_W      = 3;
   localparam int VALUE_W   = 64;

   // bit-serial step counts: one multiplier bit or one quotient bit a cycle
   localparam int MUL_STEPS = OPERAND_W;
   localparam int DIV_STEPS = VALUE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int BIT_SEL_W = $clog2(OPERAND_W);

   // saturation limits
   localparam logic [VALUE_W-1:0] MAG_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // product operator waiting for the next operand
   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_MUL  = 2'd1,
      PEND_DIV  = 2'd2
   } pend_type;

endpackage

// ----- sv/precedence_expression_evaluator.sv -----
// four-function infix evaluator with operator precedence, bit-serial arithmetic
//
// Usage: each req item carries an unsigned integer operand and the operator
// that follows it (add, subtract, multiply, divide, equals; unused codes act
// as equals). Multiply and divide bind tighter and group left to right.
// On equals one rsp item carries the signed fixed-point value with
// FRACTION_BITS fraction bits, a sticky saturation flag and a sticky
// divide-by-zero flag; the evaluator then starts a fresh expression.
// Other operators give no rsp item.
// Timing: one item is worked on at a time; req_tready is high while idle.
// An item that starts a term goes straight to the finishing step; one that
// completes a multiply runs the shift-add steps (one multiplier bit a cycle)
// and one that completes a divide runs restoring division (one quotient bit a
// cycle); a division by zero goes straight to the finishing step. The
// running-sum fold and the result register load happen in that finishing step.
// The result sits in an output register, so a stalled receiver does not stop
// the next items; only an equals item waits in its last cycle while the
// previous result is still untaken.
// Reset (synchronous, active high) clears the sum, term, flags and the
// output valid; the block is ready in the cycle after reset falls.
module precedence_expression_evaluator #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] operand
   input  logic [2:0]  req_tuser,   // [2:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result
   output logic [1:0]  rsp_tuser    // [0] overflow, [1] divide_by_zero
);
   import prec_eval_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   // control state
   state_type            state_ff,        state_in;
   pend_type             pend_ff,         pend_in;
   logic [VALUE_W-1:0]   sum_ff,          sum_in;
   logic [VALUE_W-1:0]   term_ff,         term_in;
   logic                 term_neg_ff,     term_neg_in;
   logic                 ovf_seen_ff,     ovf_seen_in;
   logic                 zdiv_seen_ff,    zdiv_seen_in;
   logic                 mul_ovf_ff,      mul_ovf_in;
   logic [CNT_W-1:0]     count_ff,        count_in;
   logic                 rsp_valid_ff,    rsp_valid_in;

   // payload registers
   logic [OPERAND_W-1:0] x_ff,            x_in;
   logic [OP_W-1:0]      op_ff,           op_in;
   logic [VALUE_W-1:0]   acc_ff,          acc_in;
   logic [OPERAND_W-1:0] rem_ff,          rem_in;
   logic [VALUE_W-1:0]   rsp_data_ff,     rsp_data_in;
   logic [1:0]           rsp_flags_ff,    rsp_flags_in;

   logic                 req_accept;
   logic                 mul_bit;
   logic [VALUE_W:0]     mul_sum;
   logic                 mul_ovf_now;
   logic [OPERAND_W:0]   div_part;
   logic [OPERAND_W:0]   div_diff;
   logic                 div_qbit;
   logic [VALUE_W:0]     fold_wide;
   logic                 fold_sat;
   logic [VALUE_W-1:0]   fold_value;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // shift-add step: accumulator doubles, multiplicand added when the bit is set
   assign mul_bit     = x_ff[count_ff[BIT_SEL_W-1:0]];
   assign mul_sum     = {acc_ff, 1'b0} + {1'b0, (mul_bit ? term_ff : '0)};
   assign mul_ovf_now = mul_ovf_ff || mul_sum[VALUE_W] || mul_sum[VALUE_W-1];

   // restoring division step: bring in the next dividend bit, try a subtract
   assign div_part = {rem_ff, term_ff[VALUE_W-1]};
   assign div_diff = div_part - {1'b0, x_ff};
   assign div_qbit = !div_diff[OPERAND_W];

   // fold the finished term into the running sum with saturation
   assign fold_wide = term_neg_ff ? ({sum_ff[VALUE_W-1], sum_ff} - {1'b0, term_ff})
                                  : ({sum_ff[VALUE_W-1], sum_ff} + {1'b0, term_ff});
   assign fold_sat  = (fold_wide[VALUE_W] != fold_wide[VALUE_W-1]);
   assign fold_value = fold_sat ? (fold_wide[VALUE_W] ? SUM_MIN : MAG_MAX)
                                : fold_wide[VALUE_W-1:0];

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      term_neg_in  = term_neg_ff;
      ovf_seen_in  = ovf_seen_ff;
      zdiv_seen_in = zdiv_seen_ff;
      mul_ovf_in   = mul_ovf_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      x_in         = x_ff;
      op_in        = op_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flags_in = rsp_flags_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               x_in  = req_tdata;
               op_in = req_tuser;
               case (pend_ff)
                  PEND_MUL: begin
                     acc_in     = '0;
                     mul_ovf_in = 1'b0;
                     count_in   = CNT_W'(MUL_STEPS - 1);
                     state_in   = S_MUL;
                  end
                  PEND_DIV: begin
                     if (req_tdata == '0) begin
                        term_in      = '0;
                        zdiv_seen_in = 1'b1;
                        state_in     = S_FINISH;
                     end else begin
                        rem_in   = '0;
                        count_in = CNT_W'(DIV_STEPS - 1);
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     term_in  = VALUE_W'(req_tdata) << FRACTION_BITS;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_MUL: begin
            acc_in     = mul_sum[VALUE_W-1:0];
            mul_ovf_in = mul_ovf_now;
            count_in   = count_ff - 1'b1;
            if (count_ff == '0) begin
               term_in     = mul_ovf_now ? MAG_MAX : mul_sum[VALUE_W-1:0];
               ovf_seen_in = ovf_seen_ff || mul_ovf_now;
               state_in    = S_FINISH;
            end
         end
         S_DIV: begin
            rem_in   = div_qbit ? div_diff[OPERAND_W-1:0] : div_part[OPERAND_W-1:0];
            term_in  = {term_ff[VALUE_W-2:0], div_qbit};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            case (op_ff)
               OP_MUL: begin
                  pend_in  = PEND_MUL;
                  state_in = S_IDLE;
               end
               OP_DIV: begin
                  pend_in  = PEND_DIV;
                  state_in = S_IDLE;
               end
               OP_ADD, OP_SUB: begin
                  sum_in      = fold_value;
                  ovf_seen_in = ovf_seen_ff || fold_sat;
                  term_neg_in = (op_ff == OP_SUB);
                  term_in     = '0;
                  pend_in     = PEND_NONE;
                  state_in    = S_IDLE;
               end
               default: begin
                  // equals: wait for the output register, then start afresh
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = fold_value;
                     rsp_flags_in = {zdiv_seen_ff, ovf_seen_ff || fold_sat};
                     sum_in       = '0;
                     term_in      = '0;
                     term_neg_in  = 1'b0;
                     pend_in      = PEND_NONE;
                     ovf_seen_in  = 1'b0;
                     zdiv_seen_in = 1'b0;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= PEND_NONE;
         sum_ff       <= '0;
         term_ff      <= '0;
         term_neg_ff  <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         zdiv_seen_ff <= 1'b0;
         mul_ovf_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         term_neg_ff  <= term_neg_in;
         ovf_seen_ff  <= ovf_seen_in;
         zdiv_seen_ff <= zdiv_seen_in;
         mul_ovf_ff   <= mul_ovf_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      op_ff        <= op_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_flags_ff <= rsp_flags_in;
   end

`ifndef NO_ASSERTIONS
   // a term waiting between items never exceeds the largest magnitude
   a_term_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !term_ff[VALUE_W-1])
      else $error("term magnitude above limit while idle");

   // the partial remainder always stays below the divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < x_ff))
      else $error("division remainder not below divisor");

   // serial steps count down by one each cycle
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL || state_ff == S_DIV) && count_ff != '0)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("serial step counter skipped");

   // a new result only comes out of the finishing step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside the finishing step");
`endif

endmodule

// ----- verif/precedence_expression_evaluator_test.sv -----
// self-checking testbench for the precedence expression evaluator
`timescale 1ns / 100ps

module precedence_expression_evaluator_test;
   import prec_eval_pkg::*;

   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 600_000;
   // longest single item (restoring divide) plus margin
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PRINT_CAP = 40;

   // codes above equals have no name in the package but behave as equals
   localparam logic [2:0] OP_UNUSED_5 = 3'd5;
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   localparam logic signed [64:0] SUM_HI = {1'b0, MAG_MAX};
   localparam logic signed [64:0] SUM_LO = {1'b1, SUM_MIN};

   typedef struct packed {
      logic [23:0] operand;
      logic [2:0]  op;
      logic        typed;
      logic [63:0] sum;
      logic        ovf;
      logic        dz;
   } stim_row_type;

   typedef struct packed {
      logic [63:0] sum;
      logic        ovf;
      logic        dz;
   } answer_type;

   // opening table: extremes, every operator, saturation both ways, zero divisor
   localparam stim_row_type OPENING_ROWS [24] = '{
      '{24'd0,      OP_EQUALS,   1'b1, 64'd0,                 1'b0, 1'b0},
      '{24'hFFFFFF, OP_EQUALS,   1'b1, 64'h0000_00FF_FFFF_0000, 1'b0, 1'b0},
      '{24'd5,      OP_DIV,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd0,      OP_EQUALS,   1'b1, 64'd0,                 1'b0, 1'b1},
      '{24'hFFFFFF, OP_MUL,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'hFFFFFF, OP_EQUALS,   1'b1, MAG_MAX,               1'b1, 1'b0},
      '{24'hFFFFFF, OP_MUL,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'hFFFFFF, OP_ADD,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd1,      OP_EQUALS,   1'b1, MAG_MAX,               1'b1, 1'b0},
      '{24'd0,      OP_SUB,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'hFFFFFF, OP_MUL,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'hFFFFFF, OP_SUB,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd1,      OP_EQUALS,   1'b1, SUM_MIN,               1'b1, 1'b0},
      '{24'd7,      OP_MUL,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd0,      OP_EQUALS,   1'b1, 64'd0,                 1'b0, 1'b0},
      '{24'd9,      OP_ADD,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd3,      OP_MUL,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd4,      OP_SUB,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd10,     OP_DIV,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd4,      OP_EQUALS,   1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd7,      OP_DIV,      1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd2,      OP_UNUSED_5, 1'b0, 64'd0,                 1'b0, 1'b0},
      '{24'd1,      OP_UNUSED_6, 1'b1, 64'h0000_0000_0001_0000, 1'b0, 1'b0},
      '{24'd3,      OP_UNUSED_7, 1'b0, 64'd0,                 1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [23:0] operand
   logic [2:0]  req_tuser = '0;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [63:0] result
   logic [1:0]  rsp_tuser;        // [0] overflow, [1] divide_by_zero

   stim_row_type driven_row = '0;
   stim_row_type item_script[$];
   answer_type   expected_answers[$];

   // evaluator state mirrored by the predictor
   logic signed [63:0] sum_acc;
   logic [63:0]        term_mag;
   logic               term_is_sub;
   pend_type           pending_op;
   logic               saturated;
   logic               zero_divided;

   int fail_count = 0;
   int cycle_count = 0;
   int items_taken = 0;
   int results_seen = 0;
   int sat_results = 0;
   int zdiv_results = 0;

   precedence_expression_evaluator #(.FRACTION_BITS(FRAC)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP) begin
         $display("mismatch @%0t: %s", $realtime, what);
      end
      fail_count++;
   endtask

   function automatic void clear_evaluator();
      sum_acc = '0;
      term_mag = '0;
      term_is_sub = 1'b0;
      pending_op = PEND_NONE;
      saturated = 1'b0;
      zero_divided = 1'b0;
   endfunction

   // one item through the evaluator; returns 1 when an expression completes
   function automatic bit evaluate_item(input logic [23:0] operand, input logic [2:0] op,
                                        output answer_type ans);
      logic [87:0]        product;
      logic signed [64:0] term_wide;
      logic signed [64:0] wide_sum;
      ans = '0;
      // finish the pending product step, or start a fresh term
      case (pending_op)
         PEND_MUL: begin
            product = term_mag * operand;
            if (product > {24'd0, MAG_MAX}) begin
               term_mag = MAG_MAX;
               saturated = 1'b1;
            end else begin
               term_mag = product[63:0];
            end
         end
         PEND_DIV: begin
            if (operand == '0) begin
               term_mag = '0;
               zero_divided = 1'b1;
            end else begin
               term_mag = term_mag / operand;
            end
         end
         default: term_mag = {40'd0, operand} << FRAC;
      endcase
      if (op == OP_MUL) begin
         pending_op = PEND_MUL;
         return 1'b0;
      end
      if (op == OP_DIV) begin
         pending_op = PEND_DIV;
         return 1'b0;
      end
      // fold the finished term into the sum with saturation
      term_wide = {1'b0, term_mag};
      wide_sum = sum_acc;
      wide_sum = term_is_sub ? wide_sum - term_wide : wide_sum + term_wide;
      if (wide_sum > SUM_HI) begin
         sum_acc = MAG_MAX;
         saturated = 1'b1;
      end else if (wide_sum < SUM_LO) begin
         sum_acc = SUM_MIN;
         saturated = 1'b1;
      end else begin
         sum_acc = wide_sum[63:0];
      end
      pending_op = PEND_NONE;
      if (op == OP_ADD || op == OP_SUB) begin
         term_is_sub = (op == OP_SUB);
         term_mag = '0;
         return 1'b0;
      end
      // equals and the unused codes close the expression
      ans.sum = sum_acc;
      ans.ovf = saturated;
      ans.dz = zero_divided;
      clear_evaluator();
      return 1'b1;
   endfunction

   function automatic logic [23:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 24'hFFFFFF;
         2, 3, 4: return 24'($urandom_range(1, 16));
         5, 6:    return 24'($urandom_range(0, 4095));
         default: return 24'($urandom());
      endcase
   endfunction

   // a well-formed expression of one to six operands with random operators
   function automatic void add_random_expression();
      int           terms;
      stim_row_type row;
      terms = $urandom_range(1, 6);
      for (int k = 0; k < terms; k++) begin
         row = '0;
         row.operand = pick_operand();
         if (k == terms - 1) begin
            case ($urandom_range(0, 9))
               0:       row.op = OP_UNUSED_5;
               1:       row.op = OP_UNUSED_6;
               2:       row.op = OP_UNUSED_7;
               default: row.op = OP_EQUALS;
            endcase
         end else begin
            case ($urandom_range(0, 3))
               0:       row.op = OP_ADD;
               1:       row.op = OP_SUB;
               2:       row.op = OP_MUL;
               default: row.op = OP_DIV;
            endcase
         end
         item_script.push_back(row);
      end
   endfunction

   // wait length for one item, with occasional stretches of no waiting
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(8, 40);
      end
      return $urandom_range(0, 7);
   endfunction

   // predict on every accepted input item
   always @(posedge clock) begin : take_req
      answer_type ans;
      if (!reset && req_tvalid && req_tready) begin
         items_taken++;
         if (evaluate_item(req_tdata, req_tuser, ans)) begin
            if (driven_row.typed) begin
               ans = '{driven_row.sum, driven_row.ovf, driven_row.dz};
            end
            expected_answers.push_back(ans);
         end
      end
   end

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : take_rsp
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
         end else begin
            want = expected_answers.pop_front();
            if (want.ovf) sat_results++;
            if (want.dz) zdiv_results++;
            if (rsp_tdata !== want.sum) begin
               report_mismatch($sformatf("result %h, expected %h", rsp_tdata, want.sum));
            end
            if (rsp_tuser[0] !== want.ovf) begin
               report_mismatch($sformatf("overflow %b, expected %b", rsp_tuser[0], want.ovf));
            end
            if (rsp_tuser[1] !== want.dz) begin
               report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                         rsp_tuser[1], want.dz));
            end
         end
      end
   end

   // receiver with random stalls
   initial begin : result_sink
      int stall;
      int burst_left;
      burst_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(burst_left);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus, drain and verdict
   initial begin : main_flow
      int gap;
      int burst_left;
      burst_left = 0;
      clear_evaluator();
      for (int i = 0; i < 24; i++) begin
         item_script.push_back(OPENING_ROWS[i]);
      end
      while (item_script.size() < 24 + RANDOM_ITEMS) begin
         add_random_expression();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (item_script[i]) begin
         gap = draw_wait(burst_left);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= item_script[i].operand;
         req_tuser <= item_script[i].op;
         driven_row <= item_script[i];
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d operand items through %0d expressions in %0d cycles",
               items_taken, results_seen, cycle_count);
      $display("%0d results saturated, %0d hit a zero divisor, %0d mismatches",
               sat_results, zdiv_results, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
